[rtl/muaf_pkg.sv]
// ----------------------------------------------------------------------------
// muaf_pkg
// Shared types and constants for the MUSCL upwind advection flux block.
// ----------------------------------------------------------------------------
package muaf_pkg;

    localparam int DW        = 32;   // width of every data field
    localparam int OPW       = 33;   // divider operand width (sums of two words)
    localparam int LAMBDA_W  = 31;
    localparam int Q_DEPTH   = 2;    // entries of each word queue
    localparam int Q_PTR_W   = 1;
    localparam int Q_CNT_W   = 2;

    typedef struct packed {
        logic                 line_start;
        logic signed [DW-1:0] density;
        logic signed [DW-1:0] momentum_x;
        logic signed [DW-1:0] momentum_y;
        logic signed [DW-1:0] pt_density;
        logic signed [DW-1:0] pt_inverse;
        logic signed [DW-1:0] tracer;
        logic signed [DW-1:0] left_face_flux;
    } t_cell;

    typedef struct packed {
        logic signed [DW-1:0] density;
        logic signed [DW-1:0] momentum_x;
        logic signed [DW-1:0] momentum_y;
        logic signed [DW-1:0] pt_density;
        logic signed [DW-1:0] tracer;
        logic                 fault;
    } t_flux;

    typedef struct packed {
        logic done;
        logic zero;     // divisor was zero
        logic sat;      // quotient clamped
    } t_div_stat;

endpackage

[rtl/muaf_front.sv]
// ----------------------------------------------------------------------------
// muaf_front
// Input side: takes cell words into a short queue and hands them to the
// back end, tagged with whether they open a new grid line.
// ----------------------------------------------------------------------------
module muaf_front
    import muaf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cell i_cell,
    output logic  o_full,
    output logic  o_valid,
    output t_cell o_cell,
    input  logic  i_take
);

    t_cell              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               wr;
    logic               rd;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cell  = r_mem[r_rp];
    assign wr      = i_push & ~o_full;
    assign rd      = i_take & o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({wr, rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/muaf_div.sv]
// ----------------------------------------------------------------------------
// muaf_div
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den,
// truncated toward zero and clamped to 32 signed bits.
// ----------------------------------------------------------------------------
module muaf_div
    import muaf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [OPW-1:0] i_num,
    input  logic signed [OPW-1:0] i_den,
    output logic signed [DW-1:0]  o_quo,
    output t_div_stat             o_stat
);

    localparam int NW  = OPW + FRAC_BITS;
    localparam int CW  = $clog2(NW + 1);

    logic [NW-1:0]  r_num;
    logic [NW-1:0]  r_quo;
    logic [OPW-1:0] r_den;
    logic [OPW-1:0] r_rem;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic           r_zero;
    logic           r_neg;
    logic [OPW-1:0] num_mag;
    logic [OPW-1:0] den_mag;
    logic [OPW:0]   rem_sh;
    logic           ge;
    logic           sat;

    assign num_mag = i_num[OPW-1] ? OPW'(-i_num) : OPW'(i_num);
    assign den_mag = i_den[OPW-1] ? OPW'(-i_den) : OPW'(i_den);
    assign rem_sh  = {r_rem, r_num[NW-1]};
    assign ge      = (rem_sh >= {1'b0, r_den});

    always_comb begin
        if (r_neg) begin
            sat = (|r_quo[NW-1:DW]) | (r_quo[DW-1] & (|r_quo[DW-2:0]));
            o_quo = sat ? {1'b1, {(DW-1){1'b0}}} : -$signed(r_quo[DW-1:0]);
        end else begin
            sat = |r_quo[NW-1:DW-1];
            o_quo = sat ? {1'b0, {(DW-1){1'b1}}} : $signed(r_quo[DW-1:0]);
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.zero = r_zero;
    assign o_stat.sat  = sat;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {num_mag, {FRAC_BITS{1'b0}}};
            r_den <= den_mag;
            r_rem <= '0;
            r_quo <= '0;
            r_neg <= i_num[OPW-1] ^ i_den[OPW-1];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= ge ? OPW'(rem_sh - {1'b0, r_den}) : rem_sh[OPW-1:0];
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(NW);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/muaf_back.sv]
// ----------------------------------------------------------------------------
// muaf_back
// Execution side: converts each cell to primitives, keeps the four-cell
// window and runs the face reconstruction and upwind flux on a shared
// divider and a shared two-pass multiplier.
// ----------------------------------------------------------------------------
module muaf_back
    import muaf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [LAMBDA_W-1:0]   i_lambda,
    input  logic                  i_valid,
    input  t_cell                 i_cell,
    output logic                  o_take,
    output logic                  o_div_go,
    output logic signed [OPW-1:0] o_div_num,
    output logic signed [OPW-1:0] o_div_den,
    input  logic signed [DW-1:0]  i_div_quo,
    input  t_div_stat             i_div_stat,
    output logic                  o_valid,
    output t_flux                 o_flux,
    input  logic                  i_ready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [2:0] D_VX = 3'd0;
    localparam logic [2:0] D_VY = 3'd1;
    localparam logic [2:0] D_TR = 3'd2;
    localparam logic [2:0] D_V1 = 3'd3;
    localparam logic [2:0] D_V2 = 3'd4;

    localparam logic [4:0] M_CL   = 5'd0;
    localparam logic [4:0] M_CR   = 5'd1;
    localparam logic [4:0] M_RLST = 5'd9;   // last reconstruction
    localparam logic [4:0] M_FD   = 5'd10;
    localparam logic [4:0] M_TX   = 5'd11;
    localparam logic [4:0] M_FMX  = 5'd12;
    localparam logic [4:0] M_TY   = 5'd13;
    localparam logic [4:0] M_FMY  = 5'd14;
    localparam logic [4:0] M_TT   = 5'd15;
    localparam logic [4:0] M_FTR  = 5'd16;

    localparam int PW = 67;
    typedef logic signed [PW-1:0] t_wide;
    localparam t_wide SMAX = t_wide'(64'sd2147483647);
    localparam t_wide SMIN = -t_wide'(64'sd2147483648);
    localparam logic signed [DW-1:0] ONE = DW'(1) << FRAC_BITS;

    logic [1:0]            r_st;
    logic [2:0]            r_dop;
    logic [4:0]            r_mop;
    logic [1:0]            r_ph;
    logic                  r_div_go;
    t_cell                 r_cell;
    logic [2:0]            r_fill;
    logic                  r_cbad;
    logic                  r_flag;

    logic signed [DW-1:0]  r_pti [4];
    logic signed [DW-1:0]  r_vx  [4];
    logic signed [DW-1:0]  r_vy  [4];
    logic signed [DW-1:0]  r_tr  [4];
    logic signed [DW-1:0]  r_pd  [4];
    logic signed [DW-1:0]  r_face[3];
    logic                  r_bad [4];

    logic signed [DW-1:0]  r_nvx, r_nvy;
    logic signed [DW-1:0]  r_v1, r_v2, r_cl, r_cr, r_t;
    logic signed [DW-1:0]  r_recl[4];
    logic signed [DW-1:0]  r_recr[4];
    logic signed [DW-1:0]  r_fd, r_fmx, r_fmy, r_ftr;

    logic [47:0]           r_plo;
    logic [48:0]           r_phi;
    logic [64:0]           r_prod;

    logic [2:0]            n_fill;
    logic                  bad_any;
    logic                  up_left;
    logic signed [DW-1:0]  chi, ux, uy, ut;
    logic [1:0]            k;
    logic signed [DW-1:0]  q0, q1, q2, q3;
    logic signed [OPW-1:0] op_a;
    logic signed [DW-1:0]  op_b;
    logic signed [OPW-1:0] op_add;
    logic                  op_sub;
    logic                  op_wide;
    logic [OPW-1:0]        a_mag;
    logic [DW-1:0]         b_mag;
    logic [64:0]           shifted;
    t_wide                 total;
    logic                  m_sat;
    logic signed [DW-1:0]  m_res;

    assign n_fill  = (r_fill < 3'd4) ? r_fill + 3'd1 : r_fill;
    assign bad_any = r_bad[0] | r_bad[1] | r_bad[2] | r_bad[3];
    assign up_left = (r_face[1] > 0);
    assign chi = up_left ? r_recl[0] : r_recr[0];
    assign ux  = up_left ? r_recl[1] : r_recr[1];
    assign uy  = up_left ? r_recl[2] : r_recr[2];
    assign ut  = up_left ? r_recl[3] : r_recr[3];

    // divider operands
    always_comb begin
        case (r_dop)
            D_VX:    o_div_num = OPW'(r_cell.momentum_x);
            D_VY:    o_div_num = OPW'(r_cell.momentum_y);
            D_TR:    o_div_num = OPW'(r_cell.tracer);
            D_V1:    o_div_num = OPW'(r_face[0]) + OPW'(r_face[1]);
            default: o_div_num = OPW'(r_face[1]) + OPW'(r_face[2]);
        endcase
        case (r_dop)
            D_V1:    o_div_den = {r_pd[1], 1'b0};
            D_V2:    o_div_den = {r_pd[2], 1'b0};
            default: o_div_den = OPW'(r_cell.density);
        endcase
    end
    assign o_div_go = r_div_go;

    // multiply-add operand selection
    assign k = 2'(5'(r_mop - 5'd2) >> 1);
    always_comb begin
        case (k)
            2'd0: begin
                q0 = r_pti[0]; q1 = r_pti[1]; q2 = r_pti[2]; q3 = r_pti[3];
            end
            2'd1: begin
                q0 = r_vx[0]; q1 = r_vx[1]; q2 = r_vx[2]; q3 = r_vx[3];
            end
            2'd2: begin
                q0 = r_vy[0]; q1 = r_vy[1]; q2 = r_vy[2]; q3 = r_vy[3];
            end
            default: begin
                q0 = r_tr[0]; q1 = r_tr[1]; q2 = r_tr[2]; q3 = r_tr[3];
            end
        endcase
    end

    always_comb begin
        op_wide = 1'b0;
        op_sub  = 1'b0;
        op_add  = '0;
        case (r_mop)
            M_CL: begin
                op_a = OPW'(r_v1); op_b = {1'b0, i_lambda};
                op_add = OPW'(ONE); op_sub = 1'b1;
            end
            M_CR: begin
                op_a = OPW'(r_v2); op_b = {1'b0, i_lambda};
                op_add = OPW'(ONE);
            end
            M_FD: begin
                op_a = OPW'(r_face[1]); op_b = chi;
            end
            M_TX: begin
                op_a = OPW'(chi); op_b = ux;
            end
            M_TY: begin
                op_a = OPW'(chi); op_b = uy;
            end
            M_TT: begin
                op_a = OPW'(chi); op_b = ut;
            end
            M_FMX, M_FMY, M_FTR: begin
                op_a = OPW'(r_face[1]); op_b = r_t;
            end
            default: begin
                op_wide = 1'b1;
                if (!r_mop[0]) begin
                    op_a = OPW'(q2) - OPW'(q0); op_b = r_cl;
                    op_add = OPW'(q1);
                end else begin
                    op_a = OPW'(q3) - OPW'(q1); op_b = r_cr;
                    op_add = OPW'(q2); op_sub = 1'b1;
                end
            end
        endcase
    end

    assign a_mag   = op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a);
    assign b_mag   = op_b[DW-1] ? DW'(-op_b) : DW'(op_b);
    assign shifted = op_wide ? (r_prod >> (FRAC_BITS + 2)) : (r_prod >> FRAC_BITS);

    always_comb begin
        if (op_a[OPW-1] ^ op_b[DW-1] ^ op_sub) begin
            total = t_wide'(op_add) - t_wide'({2'b00, shifted});
        end else begin
            total = t_wide'(op_add) + t_wide'({2'b00, shifted});
        end
        m_sat = 1'b1;
        if (total > SMAX) begin
            m_res = {1'b0, {(DW-1){1'b1}}};
        end else if (total < SMIN) begin
            m_res = {1'b1, {(DW-1){1'b0}}};
        end else begin
            m_res = total[DW-1:0];
            m_sat = 1'b0;
        end
    end

    assign o_take  = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_flux.density    = r_fd;
    assign o_flux.momentum_x = r_fmx;
    assign o_flux.momentum_y = r_fmy;
    assign o_flux.pt_density = r_face[1];
    assign o_flux.tracer     = r_ftr;
    assign o_flux.fault      = r_flag | bad_any;

    // partial products: low 16 bits then high 17 bits of the magnitude
    always_ff @(posedge i_clk) begin
        case (r_ph)
            2'd0:    r_plo  <= 48'(a_mag[15:0] * b_mag);
            2'd1:    r_phi  <= 49'(a_mag[OPW-1:16] * b_mag);
            2'd2:    r_prod <= 65'(r_plo) + (65'(r_phi) << 16);
            default: r_prod <= r_prod;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_dop    <= D_VX;
            r_mop    <= M_CL;
            r_ph     <= '0;
            r_div_go <= 1'b0;
            r_fill   <= '0;
            for (int i = 0; i < 4; i++) begin
                r_pti[i] <= '0; r_vx[i] <= '0; r_vy[i] <= '0;
                r_tr[i]  <= '0; r_pd[i] <= '0; r_bad[i] <= 1'b0;
            end
            for (int i = 0; i < 3; i++) begin
                r_face[i] <= '0;
            end
        end else begin
            r_div_go <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cell   <= i_cell;
                        r_cbad   <= 1'b0;
                        r_dop    <= D_VX;
                        r_div_go <= 1'b1;
                        r_st     <= S_DIV;
                        if (i_cell.line_start) begin
                            r_fill <= '0;
                            for (int i = 0; i < 4; i++) begin
                                r_pti[i] <= '0; r_vx[i] <= '0; r_vy[i] <= '0;
                                r_tr[i]  <= '0; r_pd[i] <= '0; r_bad[i] <= 1'b0;
                            end
                            for (int i = 0; i < 3; i++) begin
                                r_face[i] <= '0;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (i_div_stat.done) begin
                        case (r_dop)
                            D_VX: begin
                                r_nvx <= i_div_quo;
                                r_cbad <= r_cbad | i_div_stat.zero | i_div_stat.sat;
                                r_dop <= D_VY; r_div_go <= 1'b1;
                            end
                            D_VY: begin
                                r_nvy <= i_div_quo;
                                r_cbad <= r_cbad | i_div_stat.zero | i_div_stat.sat;
                                r_dop <= D_TR; r_div_go <= 1'b1;
                            end
                            D_TR: begin
                                for (int i = 0; i < 3; i++) begin
                                    r_pti[i] <= r_pti[i+1]; r_vx[i] <= r_vx[i+1];
                                    r_vy[i]  <= r_vy[i+1];  r_tr[i] <= r_tr[i+1];
                                    r_pd[i]  <= r_pd[i+1];  r_bad[i] <= r_bad[i+1];
                                end
                                r_pti[3] <= r_cell.pt_inverse;
                                r_vx[3]  <= r_nvx;
                                r_vy[3]  <= r_nvy;
                                r_tr[3]  <= i_div_quo;
                                r_pd[3]  <= r_cell.pt_density;
                                r_bad[3] <= r_cbad | i_div_stat.zero | i_div_stat.sat;
                                r_face[0] <= r_face[1];
                                r_face[1] <= r_face[2];
                                r_face[2] <= r_cell.left_face_flux;
                                r_fill <= n_fill;
                                r_flag <= 1'b0;
                                if (n_fill < 3'd4) begin
                                    r_st <= S_IDLE;
                                end else begin
                                    r_dop <= D_V1; r_div_go <= 1'b1;
                                end
                            end
                            D_V1: begin
                                r_v1 <= i_div_quo;
                                r_flag <= r_flag | i_div_stat.zero | i_div_stat.sat;
                                r_dop <= D_V2; r_div_go <= 1'b1;
                            end
                            default: begin
                                r_v2 <= i_div_quo;
                                r_flag <= r_flag | i_div_stat.zero | i_div_stat.sat;
                                r_mop <= M_CL; r_ph <= '0;
                                r_st <= S_MUL;
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd3) begin
                        r_flag <= r_flag | m_sat;
                        r_mop  <= r_mop + 5'd1;
                        case (r_mop)
                            M_CL:  r_cl  <= m_res;
                            M_CR:  r_cr  <= m_res;
                            M_FD:  r_fd  <= m_res;
                            M_FMX: r_fmx <= m_res;
                            M_FMY: r_fmy <= m_res;
                            M_FTR: r_ftr <= m_res;
                            M_TX, M_TY, M_TT: r_t <= m_res;
                            default: begin
                                if (!r_mop[0]) begin
                                    r_recl[k] <= m_res;
                                end else begin
                                    r_recr[k] <= m_res;
                                end
                            end
                        endcase
                        if (r_mop == M_RLST && r_face[1] == '0) begin
                            r_fd <= '0; r_fmx <= '0; r_fmy <= '0; r_ftr <= '0;
                            r_st <= S_OUT;
                        end else if (r_mop == M_FTR) begin
                            r_st <= S_OUT;
                        end
                    end
                end
                default: begin
                    if (i_ready) begin
                        r_st <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

[rtl/muscl_upwind_advection_flux.sv]
// ----------------------------------------------------------------------------
// muscl_upwind_advection_flux
// MUSCL upwind face flux along a grid line, signed fixed point.
// ----------------------------------------------------------------------------
// Cells of one grid line are pushed in order; line_start on the first cell of
// a line clears the four-cell window. From the fourth cell of a line on, every
// cell yields one word of face fluxes for the face between the two middle
// window cells; earlier cells yield nothing. Results leave through a two-word
// queue (empty/pop); cells enter through a two-word queue (push/full), so
// either side may stall without holding up the other. Work is done one cell
// at a time on one shared restoring divider (one quotient bit per cycle) and
// one multiplier that forms each product in a 16x32 pass and a 17x32 pass.
// A cell that yields no result needs three divisions (velocities and tracer
// ratio); one that yields a result needs two more divisions for the face
// speeds and 17 multiply-adds, or 10 when the middle face flux is zero.
// lambda is written through i_cfg_we / i_cfg_lambda; the user must write it
// only while no cell is in flight, as the block does not enforce this. fault
// flags any saturation, zero density in the window, or zero PT density in
// the middle cells.
// ----------------------------------------------------------------------------
module muscl_upwind_advection_flux
    import muaf_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [LAMBDA_W-1:0]        i_cfg_lambda,
    input  logic                       push,
    output logic                       full,
    input  logic                       i_line_start,
    input  logic signed [DW-1:0]       i_cell_density,
    input  logic signed [DW-1:0]       i_cell_momentum_x,
    input  logic signed [DW-1:0]       i_cell_momentum_y,
    input  logic signed [DW-1:0]       i_cell_pt_density,
    input  logic signed [DW-1:0]       i_cell_pt_inverse,
    input  logic signed [DW-1:0]       i_cell_tracer,
    input  logic signed [DW-1:0]       i_left_face_flux,
    output logic                       empty,
    input  logic                       pop,
    output logic signed [DW-1:0]       o_flux_density,
    output logic signed [DW-1:0]       o_flux_momentum_x,
    output logic signed [DW-1:0]       o_flux_momentum_y,
    output logic signed [DW-1:0]       o_flux_pt_density,
    output logic signed [DW-1:0]       o_flux_tracer,
    output logic                       o_fault
);

    logic [LAMBDA_W-1:0]   r_lambda;
    t_cell                 in_cell;
    logic                  fr_valid;
    t_cell                 fr_cell;
    logic                  bk_take;
    logic                  div_go;
    logic signed [OPW-1:0] div_num;
    logic signed [OPW-1:0] div_den;
    logic signed [DW-1:0]  div_quo;
    t_div_stat             div_stat;
    logic                  bk_valid;
    t_flux                 bk_flux;

    // result queue
    t_flux                 r_oq [Q_DEPTH];
    logic [Q_PTR_W-1:0]    r_owp;
    logic [Q_PTR_W-1:0]    r_orp;
    logic [Q_CNT_W-1:0]    r_ocnt;
    logic                  oq_full;
    logic                  oq_wr;
    logic                  oq_rd;
    t_flux                 head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda <= '0;
        end else if (i_cfg_we) begin
            r_lambda <= i_cfg_lambda;
        end
    end

    assign in_cell.line_start     = i_line_start;
    assign in_cell.density        = i_cell_density;
    assign in_cell.momentum_x     = i_cell_momentum_x;
    assign in_cell.momentum_y     = i_cell_momentum_y;
    assign in_cell.pt_density     = i_cell_pt_density;
    assign in_cell.pt_inverse     = i_cell_pt_inverse;
    assign in_cell.tracer         = i_cell_tracer;
    assign in_cell.left_face_flux = i_left_face_flux;

    muaf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cell  (in_cell),
        .o_full  (full),
        .o_valid (fr_valid),
        .o_cell  (fr_cell),
        .i_take  (bk_take)
    );

    muaf_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_stat  (div_stat)
    );

    muaf_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lambda   (r_lambda),
        .i_valid    (fr_valid),
        .i_cell     (fr_cell),
        .o_take     (bk_take),
        .o_div_go   (div_go),
        .o_div_num  (div_num),
        .o_div_den  (div_den),
        .i_div_quo  (div_quo),
        .i_div_stat (div_stat),
        .o_valid    (bk_valid),
        .o_flux     (bk_flux),
        .i_ready    (~oq_full)
    );

    assign oq_full = (r_ocnt == Q_CNT_W'(Q_DEPTH));
    assign empty   = (r_ocnt == '0);
    assign oq_wr   = bk_valid & ~oq_full;
    assign oq_rd   = pop & ~empty;
    assign head    = r_oq[r_orp];

    always_ff @(posedge i_clk) begin
        if (oq_wr) begin
            r_oq[r_owp] <= bk_flux;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (oq_wr) begin
                r_owp <= r_owp + 1'b1;
            end
            if (oq_rd) begin
                r_orp <= r_orp + 1'b1;
            end
            case ({oq_wr, oq_rd})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    assign o_flux_density    = head.density;
    assign o_flux_momentum_x = head.momentum_x;
    assign o_flux_momentum_y = head.momentum_y;
    assign o_flux_pt_density = head.pt_density;
    assign o_flux_tracer     = head.tracer;
    assign o_fault           = head.fault;

    // result queue never overfills
    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    // a finished result that cannot be queued is held for the next cycle
    a_bk_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (bk_valid && oq_full) |=> bk_valid)
        else $error("back end dropped a result");

    // the divider is never restarted while a cell is being taken
    a_no_take_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(bk_take && div_go))
        else $error("divider started while idle");

endmodule
